// ===== sv/bfa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bfa_pkg;

  localparam int MAX_FRAMES_DEF = 65536;

  // Map word and page geometry
  localparam int WORD_BITS  = 64;
  localparam int BIT_W      = 6;
  localparam int PAGE_SHIFT = 12;

  // Field widths
  localparam int ADDR_W   = 28;
  localparam int CNT_W    = 17;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;

  localparam logic [CNT_W-1:0] TOTAL_RESET = 17'h10000;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESERVE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_CHANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

  typedef struct packed {
    logic                clr_step;
    logic                load;
    logic                scan;
    logic                enc;
    logic                rd_target;
    logic                wr_grant;
    logic                wr_clr;
    logic                wr_set;
    logic                tally_inc;
    logic                tally_dec;
    logic                set_status;
    logic [STATUS_W-1:0] status;
    logic                out_load;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              clr_last;
    logic              hit;
    logic              scan_done;
    logic              idx_ok;
    logic              in_range;
    logic              tbit;
    logic              out_free;
  } sts_t;

  // Index of the lowest set bit; isolate it, then encode the one-hot word
  function automatic logic [BIT_W-1:0] lowest_index(input logic [WORD_BITS-1:0] v);
    logic [WORD_BITS-1:0] iso;
    logic [BIT_W-1:0]     idx;
    iso = v & (~v + WORD_BITS'(1));
    idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (iso[i]) begin
        idx = idx | BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== sv/bfa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bfa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output bfa_pkg::cmd_t      cmd,
  input  wire bfa_pkg::sts_t sts
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_ENC,
    S_GRANT,
    S_CHECK,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        // sweep the map to all used
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.kind)
          bfa_pkg::KIND_ALLOC: begin
            state_nxt = S_SCAN;
          end
          bfa_pkg::KIND_FREE, bfa_pkg::KIND_RESERVE: begin
            if (sts.in_range) begin
              cmd.rd_target = 1'b1;
              state_nxt     = S_CHECK;
            end else begin
              cmd.set_status = 1'b1;
              cmd.status     = bfa_pkg::ST_RANGE;
              state_nxt      = S_RESP;
            end
          end
          default: begin
            cmd.set_status = 1'b1;
            cmd.status     = bfa_pkg::ST_NO_CHANGE;
            state_nxt      = S_RESP;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          state_nxt = S_ENC;
        end else if (sts.scan_done) begin
          cmd.set_status = 1'b1;
          cmd.status     = bfa_pkg::ST_NO_FREE;
          state_nxt      = S_RESP;
        end
      end
      S_ENC: begin
        cmd.enc   = 1'b1;
        state_nxt = S_GRANT;
      end
      S_GRANT: begin
        cmd.set_status = 1'b1;
        // lowest free frame lies past the total: no grant
        if (sts.idx_ok) begin
          cmd.wr_grant  = 1'b1;
          cmd.tally_dec = 1'b1;
          cmd.status    = bfa_pkg::ST_DONE;
        end else begin
          cmd.status = bfa_pkg::ST_NO_FREE;
        end
        state_nxt = S_RESP;
      end
      S_CHECK: begin
        cmd.set_status = 1'b1;
        cmd.status     = bfa_pkg::ST_NO_CHANGE;
        if (sts.kind == bfa_pkg::KIND_FREE) begin
          if (sts.tbit) begin
            cmd.wr_clr    = 1'b1;
            cmd.tally_inc = 1'b1;
            cmd.status    = bfa_pkg::ST_DONE;
          end
        end else begin
          if (!sts.tbit) begin
            cmd.wr_set    = 1'b1;
            cmd.tally_dec = 1'b1;
            cmd.status    = bfa_pkg::ST_DONE;
          end
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        // hold until the output register is free
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/bfa_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bfa_dp #(
  parameter int MAX_FRAMES = bfa_pkg::MAX_FRAMES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire bfa_pkg::cmd_t                    cmd,
  output bfa_pkg::sts_t                         sts,
  input  wire logic [bfa_pkg::KIND_W-1:0]       in_kind,
  input  wire logic [bfa_pkg::ADDR_W-1:0]       in_frame_address,
  input  wire logic                             cfg_we,
  input  wire logic [bfa_pkg::CNT_W-1:0]        cfg_wdata,
  input  wire logic                             out_ready,
  output logic                                  out_valid,
  output logic [bfa_pkg::STATUS_W-1:0]          out_status,
  output logic [bfa_pkg::ADDR_W-1:0]            out_granted_address,
  output logic [bfa_pkg::CNT_W-1:0]             out_used_count,
  output logic [bfa_pkg::CNT_W-1:0]             out_free_count
);

  localparam int WordBits  = bfa_pkg::WORD_BITS;
  localparam int BitW      = bfa_pkg::BIT_W;
  localparam int CntW      = bfa_pkg::CNT_W;
  localparam int AddrW     = bfa_pkg::ADDR_W;
  localparam int PageShift = bfa_pkg::PAGE_SHIFT;
  localparam int MapWords  = (MAX_FRAMES + WordBits - 1) / WordBits;
  localparam int WordAW    = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int WordCntW  = $clog2(MapWords + 1);
  localparam int IdxW      = WordAW + BitW;
  localparam int CmpW      = ((IdxW > CntW) ? IdxW : CntW) + 1;
  localparam int CntMax    = (2 ** CntW) - 1;
  localparam int CapFrames = (MAX_FRAMES > CntMax) ? CntMax : MAX_FRAMES;
  localparam logic [CntW-1:0]     CapVal   = CntW'(CapFrames);
  localparam logic [WordCntW-1:0] LastWord = WordCntW'(MapWords - 1);
  localparam logic [WordCntW-1:0] EndWord  = WordCntW'(MapWords);

  logic [WordBits-1:0] map_mem [MapWords];

  logic [CntW-1:0]              frame_total_r;
  logic [bfa_pkg::KIND_W-1:0]   kind_r;
  logic [CmpW-1:0]              fidx_r;
  logic [WordCntW-1:0]          word_r;
  logic                         rvalid_r;
  logic [WordAW-1:0]            rword_r;
  logic [WordBits-1:0]          rdata_r;
  logic [BitW-1:0]              bit_r;
  logic [CntW-1:0]              tally_r, tally_nxt;
  logic [bfa_pkg::STATUS_W-1:0] status_r;
  logic [AddrW-1:0]             grant_r, grant_nxt;
  logic                         out_valid_r;
  logic [bfa_pkg::STATUS_W-1:0] out_status_r;
  logic [AddrW-1:0]             out_grant_r;
  logic [CntW-1:0]              out_used_r, out_free_r;

  logic [CntW-1:0]     total, used_nxt;
  logic [CmpW-1:0]     total_ext, base_ext, idx_ext;
  logic [WordAW-1:0]   fword, rd_addr, waddr;
  logic [BitW-1:0]     fbit;
  logic [WordBits-1:0] avail, wdata;
  logic                hit, exhausted, issue, rd_en, we;

  // Totals above the map size act as the map size
  assign total     = (frame_total_r > CapVal) ? CapVal : frame_total_r;
  assign total_ext = CmpW'(total);

  assign fword = fidx_r[BitW +: WordAW];
  assign fbit  = fidx_r[BitW-1:0];

  // Frame zero is never granted
  assign avail = ~rdata_r & ((rword_r == '0) ? ~WordBits'(1) : '1);
  assign hit   = rvalid_r & (|avail);

  assign base_ext  = CmpW'({word_r, {BitW{1'b0}}});
  assign exhausted = (word_r == EndWord) || (base_ext >= total_ext);
  assign issue     = cmd.scan & ~hit & ~exhausted;
  assign idx_ext   = CmpW'({rword_r, bit_r});

  assign rd_en   = issue | cmd.rd_target;
  assign rd_addr = cmd.rd_target ? fword : word_r[WordAW-1:0];

  assign we = cmd.clr_step | cmd.wr_grant | cmd.wr_clr | cmd.wr_set;

  always_comb begin
    waddr = fword;
    wdata = rdata_r | (WordBits'(1) << fbit);
    if (cmd.clr_step) begin
      waddr = word_r[WordAW-1:0];
      wdata = '1;
    end else if (cmd.wr_grant) begin
      waddr = rword_r;
      wdata = rdata_r | (WordBits'(1) << bit_r);
    end else if (cmd.wr_clr) begin
      wdata = rdata_r & ~(WordBits'(1) << fbit);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      map_mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= map_mem[rd_addr];
    end
  end

  always_comb begin
    tally_nxt = tally_r;
    if (cmd.tally_inc) begin
      tally_nxt = tally_r + CntW'(1);
    end else if (cmd.tally_dec && (tally_r != '0)) begin
      tally_nxt = tally_r - CntW'(1);
    end
  end

  always_comb begin
    grant_nxt = grant_r;
    if (cmd.load) begin
      grant_nxt = '0;
    end else if (cmd.wr_grant) begin
      grant_nxt = AddrW'({idx_ext, {PageShift{1'b0}}});
    end
  end

  assign used_nxt = (total > tally_r) ? (total - tally_r) : '0;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_total_r <= bfa_pkg::TOTAL_RESET;
      tally_r       <= '0;
      word_r        <= '0;
      rvalid_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        frame_total_r <= cfg_wdata;
      end
      tally_r  <= tally_nxt;
      rvalid_r <= issue;
      if (cmd.load) begin
        word_r <= '0;
      end else if (issue || cmd.clr_step) begin
        word_r <= word_r + WordCntW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    grant_r <= grant_nxt;
    if (cmd.load) begin
      kind_r <= in_kind;
      fidx_r <= CmpW'(in_frame_address[AddrW-1:PageShift]);
    end
    if (issue) begin
      rword_r <= word_r[WordAW-1:0];
    end
    if (cmd.enc) begin
      bit_r <= bfa_pkg::lowest_index(avail);
    end
    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
    if (cmd.out_load) begin
      out_status_r <= status_r;
      out_grant_r  <= grant_r;
      out_used_r   <= used_nxt;
      out_free_r   <= tally_r;
    end
  end

  always_comb begin
    sts           = '0;
    sts.kind      = kind_r;
    sts.clr_last  = (word_r == LastWord);
    sts.hit       = hit;
    sts.scan_done = exhausted & ~rvalid_r;
    sts.idx_ok    = (idx_ext < total_ext);
    sts.in_range  = (fidx_r < total_ext);
    sts.tbit      = rdata_r[fbit];
    sts.out_free  = ~out_valid_r | out_ready;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_granted_address = out_grant_r;
  assign out_used_count      = out_used_r;
  assign out_free_count      = out_free_r;

endmodule

`default_nettype wire

// ===== sv/bitmap_frame_allocator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Page-frame allocator over a one-bit-per-frame used map held in a single-port RAM
// (MAX_FRAMES/64 words of 64 bits) plus a free-frame tally.
// Request channel (in_valid/in_ready): in_kind 0 allocates the lowest free frame from
// index 1 below the configured total, 1 frees and 2 reserves the frame holding
// in_frame_address. Result channel (out_valid/out_ready): status, granted address,
// used and free counts. cfg_we/cfg_wdata set the frame total; the user must write it
// only while the block is idle, which the block does not enforce. One request is in
// flight at a time. Free and reserve requests inside the total pass DECODE, CHECK and
// RESP; an address past the total or an unused kind skips CHECK. An allocate passes
// DECODE, then SCAN, which reads one word per cycle from the RAM port up to the word
// holding the lowest free frame, then ENC, GRANT and RESP; one that finds none leaves
// SCAN for RESP once the words below the total are read. A new request is taken only
// in IDLE, after the last has left RESP. After reset the used map is swept to all
// used, one word a cycle, with in_ready low. Tally clears to zero, total to 65536.
// The result sits in an output register; while the receiver stalls, a new request is
// still accepted and worked on, and waits in its final step until the register frees.
module bitmap_frame_allocator_unit #(
  parameter int MAX_FRAMES = bfa_pkg::MAX_FRAMES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [bfa_pkg::KIND_W-1:0]     in_kind,
  input  wire logic [bfa_pkg::ADDR_W-1:0]     in_frame_address,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [bfa_pkg::STATUS_W-1:0]        out_status,
  output logic [bfa_pkg::ADDR_W-1:0]          out_granted_address,
  output logic [bfa_pkg::CNT_W-1:0]           out_used_count,
  output logic [bfa_pkg::CNT_W-1:0]           out_free_count,
  input  wire logic                           cfg_we,
  input  wire logic [bfa_pkg::CNT_W-1:0]      cfg_wdata
);

  bfa_pkg::cmd_t cmd;
  bfa_pkg::sts_t sts;

  bfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  bfa_dp #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_kind             (in_kind),
    .in_frame_address    (in_frame_address),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_granted_address (out_granted_address),
    .out_used_count      (out_used_count),
    .out_free_count      (out_free_count)
  );

endmodule

`default_nettype wire

// ===== sv/bfa_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bfa_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [bfa_pkg::STATUS_W-1:0]   out_status,
  input wire logic [bfa_pkg::ADDR_W-1:0]     out_granted_address,
  input wire logic [bfa_pkg::CNT_W-1:0]      out_free_count
);

  // Reset drops the result and holds off requests for the map sweep
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("result or ready present after reset");

  // Only one request in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in flight");

  // A non-zero address is only ever a successful grant
  a_grant_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_granted_address != '0) |-> out_status == bfa_pkg::ST_DONE)
    else $error("granted address with failing status");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_granted_address) && $stable(out_free_count))
    else $error("stalled result changed");

endmodule

bind bitmap_frame_allocator_unit bfa_checker u_bfa_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_status          (out_status),
  .out_granted_address (out_granted_address),
  .out_free_count      (out_free_count)
);

`default_nettype wire

// ===== verif/tb_bitmap_frame_allocator_unit.sv =====
`timescale 1ns / 1ps

import bfa_pkg::*;

localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
localparam int MAP_WORDS = MAX_FRAMES_DEF / WORD_BITS;

typedef struct packed {
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   granted;
  logic [CNT_W-1:0]    used;
  logic [CNT_W-1:0]    free_n;
} frame_result_t;

class frame_ledger;
  bit [WORD_BITS-1:0] map_words[MAP_WORDS];
  logic [CNT_W-1:0]   total_reg;
  int unsigned        tally;
  frame_result_t      pending_results[$];
  int unsigned        faults;
  int unsigned        seen;

  function new();
    foreach (map_words[w]) map_words[w] = '1;
    tally = 0;
    total_reg = TOTAL_RESET;
    faults = 0;
    seen = 0;
  endfunction

  function void set_total(logic [CNT_W-1:0] v);
    total_reg = v;
  endfunction

  function int unsigned eff_total();
    return (total_reg > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : total_reg;
  endfunction

  // Predict the outcome of one accepted request and queue it
  function void take_request(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr);
    frame_result_t      r;
    bit [WORD_BITS-1:0] avail;
    int unsigned        eff, idx, b;
    eff = eff_total();
    r = '0;
    r.status = ST_NO_CHANGE;
    if (kind == KIND_ALLOC) begin
      r.status = ST_NO_FREE;
      for (int w = 0; w < MAP_WORDS; w++) begin
        avail = ~map_words[w];
        if (w == 0) avail[0] = 1'b0;
        if (avail != '0) begin
          b = 0;
          while (!avail[b]) b++;
          idx = w * WORD_BITS + b;
          // lowest free frame lies beyond the total: nothing to grant
          if (idx < eff) begin
            map_words[w][b] = 1'b1;
            if (tally > 0) tally--;
            r.status = ST_DONE;
            r.granted = ADDR_W'(idx << PAGE_SHIFT);
          end
          break;
        end
      end
    end else if (kind == KIND_FREE || kind == KIND_RESERVE) begin
      idx = addr >> PAGE_SHIFT;
      if (idx >= eff) begin
        r.status = ST_RANGE;
      end else if (kind == KIND_FREE) begin
        if (map_words[idx / WORD_BITS][idx % WORD_BITS]) begin
          map_words[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
          tally++;
          r.status = ST_DONE;
        end
      end else begin
        if (!map_words[idx / WORD_BITS][idx % WORD_BITS]) begin
          map_words[idx / WORD_BITS][idx % WORD_BITS] = 1'b1;
          if (tally > 0) tally--;
          r.status = ST_DONE;
        end
      end
    end
    r.used = (eff > tally) ? CNT_W'(eff - tally) : '0;
    r.free_n = (tally > 17'h1FFFF) ? 17'h1FFFF : CNT_W'(tally);
    pending_results.push_back(r);
  endfunction

  task report_mismatch(string what, longint unsigned want, longint unsigned got);
    faults++;
    $display("result %0d: %s expected 0x%0h, got 0x%0h", seen, what, want, got);
  endtask

  task match_result(logic [STATUS_W-1:0] status, logic [ADDR_W-1:0] granted,
                    logic [CNT_W-1:0] used, logic [CNT_W-1:0] free_n);
    frame_result_t e;
    seen++;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected result, status", 0, status);
    end else begin
      e = pending_results.pop_front();
      if (status !== e.status) report_mismatch("status", e.status, status);
      if (granted !== e.granted) report_mismatch("granted_address", e.granted, granted);
      if (used !== e.used) report_mismatch("used_count", e.used, used);
      if (free_n !== e.free_n) report_mismatch("free_count", e.free_n, free_n);
    end
  endtask
endclass

module tb_bitmap_frame_allocator_unit;

  localparam int STALL_LIMIT = 10000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_ITEMS = 94;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [KIND_W-1:0]   in_kind = KIND_ALLOC;
  logic [ADDR_W-1:0]   in_frame_address = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [ADDR_W-1:0]   out_granted_address;
  logic [CNT_W-1:0]    out_used_count;
  logic [CNT_W-1:0]    out_free_count;
  logic                cfg_we = 1'b0;
  logic [CNT_W-1:0]    cfg_wdata = '0;

  frame_ledger ledger = new();
  bit          feed_steady = 1'b0;
  bit          sink_steady = 1'b0;
  int          quiet_cycles = 0;

  bitmap_frame_allocator_unit uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_frame_address    (in_frame_address),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_granted_address (out_granted_address),
    .out_used_count      (out_used_count),
    .out_free_count      (out_free_count),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hold valid across back-to-back requests; drop it only for a real gap
  task send_request(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr);
    int gap;
    gap = feed_steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_frame_address <= addr;
    do @(posedge clk); while (in_ready !== 1'b1);
    ledger.take_request(kind, addr);
  endtask

  task drain_results();
    in_valid <= 1'b0;
    while (ledger.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_total(input logic [CNT_W-1:0] v);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    ledger.set_total(v);
  endtask

  function automatic logic [ADDR_W-1:0] pick_address(int unsigned eff);
    int unsigned r, span, idx;
    r = $urandom_range(0, 99);
    span = (eff < 256) ? eff + 2 : 256;
    if (r < 80) begin
      idx = $urandom_range(0, span - 1);
    end else if (r < 90) begin
      return ADDR_W'($urandom);
    end else begin
      // straddle the edge of the map
      idx = eff + $urandom_range(0, 2);
      idx = (idx > 0) ? idx - 1 : 0;
      if (idx > MAX_FRAMES_DEF - 1) idx = MAX_FRAMES_DEF - 1;
    end
    return {idx[15:0], 12'($urandom)};
  endfunction

  task run_phase(input int items);
    int unsigned r;
    logic [KIND_W-1:0] kind;
    feed_steady = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 38) kind = KIND_FREE;
      else if (r < 73) kind = KIND_ALLOC;
      else if (r < 95) kind = KIND_RESERVE;
      else kind = KIND_UNUSED;
      send_request(kind, pick_address(ledger.eff_total()));
    end
  endtask

  initial begin
    int stall;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) sink_steady = !sink_steady;
      stall = sink_steady ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      ledger.match_result(out_status, out_granted_address, out_used_count, out_free_count);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    logic [CNT_W-1:0] phase_totals[12];
    phase_totals = '{17'h10000, 17'd1, 17'd64, 17'd65, 17'd300, 17'hFFFF,
                     CNT_W'($urandom_range(0, 17'h1FFFF)), 17'd2, 17'h1FFFF,
                     CNT_W'($urandom_range(0, 17'h10000)), 17'd129, 17'h10000};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // every frame starts used, and frame zero is never granted
    send_request(KIND_ALLOC,   28'h0000000);
    send_request(KIND_FREE,    28'h0000000);
    send_request(KIND_FREE,    28'h0000FFF);
    send_request(KIND_ALLOC,   28'h0000000);
    send_request(KIND_RESERVE, 28'h0000000);
    send_request(KIND_RESERVE, 28'h0000000);
    send_request(KIND_FREE,    28'h0001FFF);
    send_request(KIND_ALLOC,   28'hFFFFFFF);
    send_request(KIND_UNUSED,  28'hFFFFFFF);
    send_request(KIND_FREE,    28'hFFFFFFF);
    send_request(KIND_ALLOC,   28'h0000000);
    send_request(KIND_FREE,    28'hFFFF000);
    send_request(KIND_RESERVE, 28'hFFFFFFF);
    send_request(KIND_RESERVE, 28'hFFFFFFF);
    send_request(KIND_FREE,    28'h0002000);
    // shrink the map below a free frame: it stays free but is out of reach
    write_total(17'd2);
    send_request(KIND_FREE,    28'h0002000);
    send_request(KIND_ALLOC,   28'h0000000);
    send_request(KIND_RESERVE, 28'h0001000);
    write_total(17'd0);
    send_request(KIND_FREE,    28'h0000000);
    send_request(KIND_ALLOC,   28'h0000000);
    write_total(17'h1FFFF);
    send_request(KIND_ALLOC,   28'h0000000);
    send_request(KIND_FREE,    28'hFFFFFFF);
    send_request(KIND_RESERVE, 28'hFFFFFFF);

    foreach (phase_totals[p]) begin
      write_total(phase_totals[p]);
      run_phase(PHASE_ITEMS);
    end

    drain_results();
    if (ledger.faults == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
